// ===== src/tbtl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tbtl_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_DRAW  = 2'd0;
  localparam action_t ACT_WAIT  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ORIGIN_X     = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_Y     = 3'd1;
  localparam cfg_idx_t REG_INK_COLOR    = 3'd2;
  localparam cfg_idx_t REG_LINE_WIDTH   = 3'd3;
  localparam cfg_idx_t REG_LETTER_DELAY = 3'd4;
  localparam cfg_idx_t REG_TILE_BASE    = 3'd5;

  localparam logic [7:0] CH_ESCAPE  = 8'h40;
  localparam logic [7:0] CH_NEWLINE = 8'h53;
  localparam logic [7:0] CH_WAIT    = 8'h57;
  localparam logic [7:0] CH_CLEAR   = 8'h43;

  localparam logic [7:0] UPPER_LO   = 8'd64;
  localparam logic [7:0] UPPER_HI   = 8'd90;
  localparam logic [7:0] HIGH_LO    = 8'd192;
  localparam logic [7:0] HIGH_SHIFT = 8'd128;
  localparam logic [7:0] CASE_SHIFT = 8'd32;
  localparam logic [7:0] TILE_SHIFT = 8'd32;

  localparam logic [3:0] INK_RESET = 4'd1;

  function automatic logic [7:0] remap_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c > UPPER_LO && c <= UPPER_HI) begin
      r = c + CASE_SHIFT;
    end else if (c > HIGH_LO) begin
      r = c - HIGH_SHIFT;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/text_block_tile_layout_core.sv =====
// An input transfer passes through the input register and then the result register.
// Throughput: one byte per cycle unless stalled; escape bytes and new lines produce no result.
// While a finished result waits on out_stall the input register takes one more byte, then stalls.
// Synchronous active-low reset clears the cursor, the escape flag and the pipeline
// valids, and loads the register defaults (ink color 1, all others 0).
`timescale 1ns / 1ps
`default_nettype none
module text_block_tile_layout_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire tbtl_pkg::cfg_idx_t         cfg_index,
  input  wire logic [7:0]                 cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_char_code,
  input  wire logic                       in_block_start,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output tbtl_pkg::action_t               out_action,
  output logic [7:0]                      out_pos_x,
  output logic [7:0]                      out_pos_y,
  output logic [7:0]                      out_tile_code,
  output logic [3:0]                      out_tile_color,
  output logic [7:0]                      out_delay_frames,
  output logic [7:0]                      out_clear_rows,
  output logic [7:0]                      out_clear_cols
);
  import tbtl_pkg::*;

  logic [7:0] origin_x_r, origin_y_r, line_width_r, letter_delay_r, tile_base_r;
  logic [3:0] ink_color_r;

  logic       esc_r, esc_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_start_r;
  logic       s1_adv;
  logic       s1_fire;

  logic       out_valid_r, out_valid_nxt;
  action_t    act_r, act_nxt;
  logic [7:0] pos_x_r, pos_x_nxt;
  logic [7:0] pos_y_r, pos_y_nxt;
  logic [7:0] tile_r, tile_nxt;
  logic [3:0] color_r, color_nxt;
  logic [7:0] delay_r, delay_nxt;
  logic [7:0] crows_r, crows_nxt;
  logic [7:0] ccols_r, ccols_nxt;

  logic       has_result;
  logic       esc_eff;
  logic [7:0] col_eff, row_eff, col_inc;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      ink_color_r    <= INK_RESET;
      line_width_r   <= '0;
      letter_delay_r <= '0;
      tile_base_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:     origin_x_r     <= cfg_data;
        REG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        REG_INK_COLOR:    ink_color_r    <= cfg_data[3:0];
        REG_LINE_WIDTH:   line_width_r   <= cfg_data;
        REG_LETTER_DELAY: letter_delay_r <= cfg_data;
        REG_TILE_BASE:    tile_base_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r  <= in_char_code;
      s1_start_r <= in_block_start;
    end
  end

  always_comb begin
    esc_eff = s1_start_r ? 1'b0 : esc_r;
    col_eff = s1_start_r ? 8'd0 : col_r;
    row_eff = s1_start_r ? origin_y_r : row_r;
    col_inc = col_eff + 8'd1;

    esc_nxt    = esc_eff;
    col_nxt    = col_eff;
    row_nxt    = row_eff;
    has_result = 1'b0;

    act_nxt   = ACT_DRAW;
    pos_x_nxt = '0;
    pos_y_nxt = '0;
    tile_nxt  = '0;
    color_nxt = '0;
    delay_nxt = '0;
    crows_nxt = '0;
    ccols_nxt = '0;

    if (esc_eff) begin
      esc_nxt = 1'b0;
      case (s1_char_r)
        CH_NEWLINE: begin
          col_nxt = 8'd0;
          row_nxt = row_eff + 8'd1;
        end
        CH_WAIT: begin
          has_result = 1'b1;
          act_nxt    = ACT_WAIT;
        end
        CH_CLEAR: begin
          has_result = 1'b1;
          act_nxt    = ACT_CLEAR;
          pos_x_nxt  = origin_x_r;
          pos_y_nxt  = origin_y_r;
          crows_nxt  = row_eff;
          ccols_nxt  = line_width_r;
          row_nxt    = origin_y_r;
          col_nxt    = 8'd0;
        end
        default: ;
      endcase
    end else if (s1_char_r == CH_ESCAPE) begin
      esc_nxt = 1'b1;
    end else begin
      has_result = 1'b1;
      act_nxt    = ACT_DRAW;
      pos_x_nxt  = origin_x_r + col_eff;
      pos_y_nxt  = row_eff;
      tile_nxt   = remap_byte(s1_char_r) - TILE_SHIFT + tile_base_r;
      color_nxt  = ink_color_r;
      delay_nxt  = letter_delay_r;
      col_nxt    = col_inc;
      if (line_width_r != 8'd0 && col_inc >= line_width_r) begin
        col_nxt = 8'd0;
        row_nxt = row_eff + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
    end else if (s1_fire) begin
      esc_r <= esc_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = has_result;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      act_r   <= act_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      tile_r  <= tile_nxt;
      color_r <= color_nxt;
      delay_r <= delay_nxt;
      crows_r <= crows_nxt;
      ccols_r <= ccols_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = act_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_tile_code    = tile_r;
  assign out_tile_color   = color_r;
  assign out_delay_frames = delay_r;
  assign out_clear_rows   = crows_r;
  assign out_clear_cols   = ccols_r;

endmodule
`default_nettype wire
